>>> hw/rtl/nec_ir_pkg.sv
// ---------------------------------------------------------------------------
// nec_ir_pkg
// Shared types, widths and codes for the NEC infrared frame decoder.
// ---------------------------------------------------------------------------
package nec_ir_pkg;

   localparam int TICK_W   = 15;
   localparam int HALF_W   = 16;
   localparam int KEY_W    = 8;
   localparam int STAT_W   = 2;
   localparam int CNT_W    = 7;
   localparam int POS_W    = 4;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 16;

   localparam int REPEAT_MARK_TICKS_DEF = 9000;
   localparam int MAX_SYMBOLS_DEF       = 64;

   localparam logic [CNT_W-1:0] FRAME_LEN  = CNT_W'(34);
   localparam logic [CNT_W-1:0] REPEAT_LEN = CNT_W'(2);
   localparam logic [CNT_W-1:0] DATA_LAST  = CNT_W'(2 * HALF_W);
   localparam logic [CNT_W-1:0] ADDR_LAST  = CNT_W'(HALF_W);

   localparam logic [STAT_W-1:0] ST_NEW     = 2'd0;
   localparam logic [STAT_W-1:0] ST_REPEAT  = 2'd1;
   localparam logic [STAT_W-1:0] ST_REJECT  = 2'd2;
   localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_LEADER_MARK  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEADER_SPACE = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_MARK    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_SPACE   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_MARK     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_SPACE    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_SPACE = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE    = 4'd7;

   typedef struct packed {
      logic [TICK_W-1:0] leader_mark;
      logic [TICK_W-1:0] leader_space;
      logic [TICK_W-1:0] zero_mark;
      logic [TICK_W-1:0] zero_space;
      logic [TICK_W-1:0] one_mark;
      logic [TICK_W-1:0] one_space;
      logic [TICK_W-1:0] repeat_space;
      logic [TICK_W-1:0] tolerance;
   } cfg_type;

   typedef struct packed {
      logic [TICK_W-1:0] mark_ticks;
      logic [TICK_W-1:0] space_ticks;
      logic              burst_end;
   } sym_type;

   typedef struct packed {
      logic leader;
      logic repeat_lead;
      logic zero;
      logic one;
   } match_type;

endpackage

>>> hw/rtl/nec_ir_frame_decoder.sv
// ---------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC infrared frame decoder: one mark/space symbol per item, one result per
// burst end.
// ---------------------------------------------------------------------------
// Accepts one symbol item every clock cycle while req_stall is low. A symbol
// is held in an input register, classified against the programmed timing
// windows and folded into the burst state when it is taken from there; a
// burst end also writes the result register, which then offers the result.
// The result register and input register decouple the two channels: new
// symbols keep flowing while a result waits, and only a second burst end
// stalls behind an untaken result. The timing registers are written through
// the csr_ port, which is always ready, and take effect for the next symbol.
module nec_ir_frame_decoder #(
   parameter int REPEAT_MARK_TICKS = nec_ir_pkg::REPEAT_MARK_TICKS_DEF,
   parameter int MAX_SYMBOLS       = nec_ir_pkg::MAX_SYMBOLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [nec_ir_pkg::TICK_W-1:0]     req_mark_ticks,
   input  logic [nec_ir_pkg::TICK_W-1:0]     req_space_ticks,
   input  logic                              req_burst_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [nec_ir_pkg::STAT_W-1:0]     rsp_status,
   output logic [nec_ir_pkg::HALF_W-1:0]     rsp_device_address,
   output logic [nec_ir_pkg::HALF_W-1:0]     rsp_device_command,
   output logic [nec_ir_pkg::KEY_W-1:0]      rsp_key_code,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nec_ir_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nec_ir_pkg::CSR_DAT_W-1:0]  csr_wdata
);

   nec_ir_pkg::cfg_type    cfg;
   nec_ir_pkg::sym_type    sym;
   nec_ir_pkg::match_type  hit;
   logic                   sym_valid;
   logic                   take;

   nec_ir_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nec_ir_in_stage u_in_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mark_ticks  (req_mark_ticks),
      .req_space_ticks (req_space_ticks),
      .req_burst_end   (req_burst_end),
      .take            (take),
      .sym_valid       (sym_valid),
      .sym             (sym)
   );

   nec_ir_classify #(
      .REPEAT_MARK_TICKS (REPEAT_MARK_TICKS)
   ) u_classify (
      .sym (sym),
      .cfg (cfg),
      .hit (hit)
   );

   nec_ir_frame #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_frame (
      .clock              (clock),
      .reset              (reset),
      .sym_valid          (sym_valid),
      .sym_last           (sym.burst_end),
      .hit                (hit),
      .take               (take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_device_address (rsp_device_address),
      .rsp_device_command (rsp_device_command),
      .rsp_key_code       (rsp_key_code)
   );

endmodule

>>> hw/rtl/nec_ir_csr.sv
// ---------------------------------------------------------------------------
// nec_ir_csr
// Timing register file, written through the configuration port.
// ---------------------------------------------------------------------------
module nec_ir_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nec_ir_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nec_ir_pkg::CSR_DAT_W-1:0]    csr_wdata,
   output nec_ir_pkg::cfg_type                 cfg
);

   nec_ir_pkg::cfg_type       cfg_ff;
   nec_ir_pkg::cfg_type       cfg_in;
   logic [nec_ir_pkg::TICK_W-1:0] wval;

   assign csr_ready = 1'b1;
   assign wval      = csr_wdata[nec_ir_pkg::TICK_W-1:0];
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            nec_ir_pkg::REG_LEADER_MARK:  cfg_in.leader_mark  = wval;
            nec_ir_pkg::REG_LEADER_SPACE: cfg_in.leader_space = wval;
            nec_ir_pkg::REG_ZERO_MARK:    cfg_in.zero_mark    = wval;
            nec_ir_pkg::REG_ZERO_SPACE:   cfg_in.zero_space   = wval;
            nec_ir_pkg::REG_ONE_MARK:     cfg_in.one_mark     = wval;
            nec_ir_pkg::REG_ONE_SPACE:    cfg_in.one_space    = wval;
            nec_ir_pkg::REG_REPEAT_SPACE: cfg_in.repeat_space = wval;
            nec_ir_pkg::REG_TOLERANCE:    cfg_in.tolerance    = wval;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_mark  <= nec_ir_pkg::TICK_W'(9000);
         cfg_ff.leader_space <= nec_ir_pkg::TICK_W'(4500);
         cfg_ff.zero_mark    <= nec_ir_pkg::TICK_W'(560);
         cfg_ff.zero_space   <= nec_ir_pkg::TICK_W'(560);
         cfg_ff.one_mark     <= nec_ir_pkg::TICK_W'(560);
         cfg_ff.one_space    <= nec_ir_pkg::TICK_W'(1690);
         cfg_ff.repeat_space <= nec_ir_pkg::TICK_W'(2250);
         cfg_ff.tolerance    <= nec_ir_pkg::TICK_W'(200);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/nec_ir_in_stage.sv
// ---------------------------------------------------------------------------
// nec_ir_in_stage
// Input register for one symbol item, with stall toward the sender.
// ---------------------------------------------------------------------------
module nec_ir_in_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [nec_ir_pkg::TICK_W-1:0]    req_mark_ticks,
   input  logic [nec_ir_pkg::TICK_W-1:0]    req_space_ticks,
   input  logic                             req_burst_end,
   input  logic                             take,
   output logic                             sym_valid,
   output nec_ir_pkg::sym_type              sym
);

   logic                    valid_ff;
   logic                    valid_in;
   logic                    load;
   nec_ir_pkg::sym_type     sym_ff;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;
   assign sym_valid = valid_ff;
   assign sym       = sym_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sym_ff.mark_ticks  <= req_mark_ticks;
         sym_ff.space_ticks <= req_space_ticks;
         sym_ff.burst_end   <= req_burst_end;
      end
   end

endmodule

>>> hw/rtl/nec_ir_classify.sv
// ---------------------------------------------------------------------------
// nec_ir_classify
// Window checks of one symbol against the leader, repeat and bit timings.
// ---------------------------------------------------------------------------
module nec_ir_classify #(
   parameter int REPEAT_MARK_TICKS = nec_ir_pkg::REPEAT_MARK_TICKS_DEF
) (
   input  nec_ir_pkg::sym_type    sym,
   input  nec_ir_pkg::cfg_type    cfg,
   output nec_ir_pkg::match_type  hit
);

   localparam logic [nec_ir_pkg::TICK_W-1:0] REP_MARK = nec_ir_pkg::TICK_W'(REPEAT_MARK_TICKS);

   function automatic logic in_window(
      input logic [nec_ir_pkg::TICK_W-1:0] d,
      input logic [nec_ir_pkg::TICK_W-1:0] nom,
      input logic [nec_ir_pkg::TICK_W-1:0] tol
   );
      logic [nec_ir_pkg::TICK_W:0]   hi;
      logic [nec_ir_pkg::TICK_W-1:0] lo;
      hi = {1'b0, nom} + {1'b0, tol};
      lo = (nom > tol) ? (nom - tol) : '0;
      return ({1'b0, d} < hi) && (d > lo);
   endfunction

   always_comb begin
      hit.leader      = in_window(sym.mark_ticks, cfg.leader_mark, cfg.tolerance) &&
                        in_window(sym.space_ticks, cfg.leader_space, cfg.tolerance);
      hit.repeat_lead = in_window(sym.mark_ticks, REP_MARK, cfg.tolerance) &&
                        in_window(sym.space_ticks, cfg.repeat_space, cfg.tolerance);
      hit.zero        = in_window(sym.mark_ticks, cfg.zero_mark, cfg.tolerance) &&
                        in_window(sym.space_ticks, cfg.zero_space, cfg.tolerance);
      hit.one         = in_window(sym.mark_ticks, cfg.one_mark, cfg.tolerance) &&
                        in_window(sym.space_ticks, cfg.one_space, cfg.tolerance);
   end

endmodule

>>> hw/rtl/nec_ir_frame.sv
// ---------------------------------------------------------------------------
// nec_ir_frame
// Burst state, bit assembly, stored frame and result register.
// ---------------------------------------------------------------------------
module nec_ir_frame #(
   parameter int MAX_SYMBOLS = nec_ir_pkg::MAX_SYMBOLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              sym_valid,
   input  logic                              sym_last,
   input  nec_ir_pkg::match_type             hit,
   output logic                              take,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [nec_ir_pkg::STAT_W-1:0]     rsp_status,
   output logic [nec_ir_pkg::HALF_W-1:0]     rsp_device_address,
   output logic [nec_ir_pkg::HALF_W-1:0]     rsp_device_command,
   output logic [nec_ir_pkg::KEY_W-1:0]      rsp_key_code
);

   localparam logic [nec_ir_pkg::CNT_W-1:0] CNT_MAX = nec_ir_pkg::CNT_W'(MAX_SYMBOLS);

   logic [nec_ir_pkg::CNT_W-1:0]  count_ff, count_in, count_inc, idx_m1;
   logic                          frame_ok_ff, frame_ok_in;
   logic                          repeat_ok_ff, repeat_ok_in;
   logic [nec_ir_pkg::HALF_W-1:0] addr_sh_ff, addr_sh_in;
   logic [nec_ir_pkg::HALF_W-1:0] cmd_sh_ff, cmd_sh_in;
   logic [nec_ir_pkg::HALF_W-1:0] saved_addr_ff, saved_addr_in;
   logic [nec_ir_pkg::HALF_W-1:0] saved_cmd_ff, saved_cmd_in;
   logic [nec_ir_pkg::POS_W-1:0]  pos;
   logic                          bit_val;
   logic [nec_ir_pkg::STAT_W-1:0] status_in;
   logic                          out_free;
   logic                          emit;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [nec_ir_pkg::STAT_W-1:0] status_ff;
   logic [nec_ir_pkg::HALF_W-1:0] addr_ff, cmd_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = sym_valid && (!sym_last || out_free);
   assign emit     = take && sym_last;
   assign idx_m1   = count_ff - nec_ir_pkg::CNT_W'(1);
   assign pos      = idx_m1[nec_ir_pkg::POS_W-1:0];
   assign bit_val  = !hit.zero && hit.one;

   always_comb begin
      frame_ok_in   = frame_ok_ff;
      repeat_ok_in  = repeat_ok_ff;
      addr_sh_in    = addr_sh_ff;
      cmd_sh_in     = cmd_sh_ff;
      saved_addr_in = saved_addr_ff;
      saved_cmd_in  = saved_cmd_ff;
      status_in     = nec_ir_pkg::ST_UNKNOWN;

      if (count_ff == '0) begin
         frame_ok_in  = hit.leader;
         repeat_ok_in = hit.repeat_lead;
      end else if (count_ff <= nec_ir_pkg::DATA_LAST) begin
         if (!hit.zero && !hit.one) begin
            frame_ok_in = 1'b0;
         end
         if (count_ff <= nec_ir_pkg::ADDR_LAST) begin
            addr_sh_in[pos] = bit_val;
         end else begin
            cmd_sh_in[pos] = bit_val;
         end
      end

      count_inc = (count_ff < CNT_MAX) ? (count_ff + nec_ir_pkg::CNT_W'(1)) : count_ff;
      count_in  = count_inc;

      if (sym_last) begin
         if (count_inc == nec_ir_pkg::FRAME_LEN) begin
            if (frame_ok_in) begin
               saved_addr_in = addr_sh_in;
               saved_cmd_in  = cmd_sh_in;
               status_in     = nec_ir_pkg::ST_NEW;
            end else begin
               status_in = nec_ir_pkg::ST_REJECT;
            end
         end else if (count_inc == nec_ir_pkg::REPEAT_LEN) begin
            status_in = repeat_ok_in ? nec_ir_pkg::ST_REPEAT : nec_ir_pkg::ST_REJECT;
         end else begin
            status_in = nec_ir_pkg::ST_UNKNOWN;
         end
         count_in     = '0;
         frame_ok_in  = 1'b1;
         repeat_ok_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         frame_ok_ff   <= 1'b1;
         repeat_ok_ff  <= 1'b0;
         addr_sh_ff    <= '0;
         cmd_sh_ff     <= '0;
         saved_addr_ff <= '0;
         saved_cmd_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            count_ff      <= count_in;
            frame_ok_ff   <= frame_ok_in;
            repeat_ok_ff  <= repeat_ok_in;
            addr_sh_ff    <= addr_sh_in;
            cmd_sh_ff     <= cmd_sh_in;
            saved_addr_ff <= saved_addr_in;
            saved_cmd_ff  <= saved_cmd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff <= status_in;
         addr_ff   <= saved_addr_in;
         cmd_ff    <= saved_cmd_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_device_address = addr_ff;
   assign rsp_device_command = cmd_ff;
   assign rsp_key_code       = cmd_ff[nec_ir_pkg::KEY_W-1:0];

endmodule

>>> hw/rtl/nec_ir_checker.sv
// ---------------------------------------------------------------------------
// nec_ir_checker
// Port-level checks for the NEC infrared frame decoder, bound to the top.
// ---------------------------------------------------------------------------
module nec_ir_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [nec_ir_pkg::STAT_W-1:0]     rsp_status,
   input logic [nec_ir_pkg::HALF_W-1:0]     rsp_device_address,
   input logic [nec_ir_pkg::HALF_W-1:0]     rsp_device_command,
   input logic [nec_ir_pkg::KEY_W-1:0]      rsp_key_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_device_address) && $stable(rsp_device_command))
      else $error("result item changed while stalled");

   a_key_low_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_key_code == rsp_device_command[nec_ir_pkg::KEY_W-1:0])
      else $error("key code differs from command low byte");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item right after reset");

   a_new_keeps_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall ##1 rsp_valid &&
      (rsp_status == nec_ir_pkg::ST_REJECT || rsp_status == nec_ir_pkg::ST_REPEAT) &&
      $past(rsp_status) != nec_ir_pkg::ST_NEW |->
      rsp_device_address == $past(rsp_device_address) &&
      rsp_device_command == $past(rsp_device_command))
      else $error("stored frame changed without a new frame");

endmodule

bind nec_ir_frame_decoder nec_ir_checker u_checker (.*);

>>> tb/tb_nec_ir_frame_decoder.sv
// ---------------------------------------------------------------------------
// tb_nec_ir_frame_decoder
// Self-checking bench for the NEC infrared frame decoder. Symbol items are
// queued burst by burst and fed by a clocked driver with random gaps; a
// clocked monitor with random back-pressure compares every report field by
// field against a cycle-free model of the decoder. The run walks through
// several timing setups, from the standard NEC values to empty and
// all-covering windows, and ends with a stretch free of idling.
// ---------------------------------------------------------------------------
module tb_nec_ir_frame_decoder;

   localparam int TICK_MAX   = (1 << nec_ir_pkg::TICK_W) - 1;
   localparam int WATCH_MAX  = 4000;
   localparam int HOLD_LEN   = 400;
   localparam int HOLD_AFTER = 12;

   localparam nec_ir_pkg::cfg_type NEC_STD = {15'd9000, 15'd4500, 15'd560, 15'd560,
                                              15'd560, 15'd1690, 15'd2250, 15'd200};

   typedef struct {
      logic [nec_ir_pkg::STAT_W-1:0] status;
      logic [nec_ir_pkg::HALF_W-1:0] address;
      logic [nec_ir_pkg::HALF_W-1:0] command;
      logic [nec_ir_pkg::KEY_W-1:0]  key;
   } ir_report_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [nec_ir_pkg::TICK_W-1:0]       req_mark_ticks = '0;
   logic [nec_ir_pkg::TICK_W-1:0]       req_space_ticks = '0;
   logic                                req_burst_end = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [nec_ir_pkg::STAT_W-1:0]       rsp_status;
   logic [nec_ir_pkg::HALF_W-1:0]       rsp_device_address;
   logic [nec_ir_pkg::HALF_W-1:0]       rsp_device_command;
   logic [nec_ir_pkg::KEY_W-1:0]        rsp_key_code;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [nec_ir_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [nec_ir_pkg::CSR_DAT_W-1:0]    csr_wdata = '0;
   logic [nec_ir_pkg::TICK_W-1:0]       csr_tick;

   // decoder model
   nec_ir_pkg::cfg_type           cfg_now = NEC_STD;
   int unsigned                   count_seen = 0;
   bit                            frame_good = 1'b1;
   bit                            repeat_good = 1'b0;
   logic [nec_ir_pkg::HALF_W-1:0] addr_bits = '0;
   logic [nec_ir_pkg::HALF_W-1:0] cmd_bits = '0;
   logic [nec_ir_pkg::HALF_W-1:0] held_addr = '0;
   logic [nec_ir_pkg::HALF_W-1:0] held_cmd = '0;

   ir_report_type        reports_due[$];
   nec_ir_pkg::sym_type  pending[$];
   nec_ir_pkg::sym_type  next_sym;
   ir_report_type        want_report;

   int unsigned symbols_queued = 0;
   int unsigned symbols_sent = 0;
   int unsigned reports_seen = 0;
   int unsigned status_tally[4] = '{0, 0, 0, 0};
   int unsigned errors = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   int unsigned stuck_cycles = 0;
   int unsigned setups_run = 1;
   bit          held_off = 1'b0;
   bit          calm_tail = 1'b0;
   bit          sent_now;

   assign csr_tick = csr_wdata[nec_ir_pkg::TICK_W-1:0];

   nec_ir_frame_decoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mark_ticks     (req_mark_ticks),
      .req_space_ticks    (req_space_ticks),
      .req_burst_end      (req_burst_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_device_address (rsp_device_address),
      .rsp_device_command (rsp_device_command),
      .rsp_key_code       (rsp_key_code),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic bit in_window(input int unsigned d, input int unsigned nom);
      int unsigned lo_b;
      int unsigned hi_b;
      lo_b = (nom > cfg_now.tolerance) ? nom - cfg_now.tolerance : 0;
      hi_b = nom + cfg_now.tolerance;
      return (d < hi_b) && (d > lo_b);
   endfunction

   function automatic bit pair_hits(input int unsigned m, input int unsigned s,
                                    input int unsigned nm, input int unsigned ns);
      return in_window(m, nm) && in_window(s, ns);
   endfunction

   task automatic decode_symbol(input logic [nec_ir_pkg::TICK_W-1:0] m,
                                input logic [nec_ir_pkg::TICK_W-1:0] s,
                                input logic last);
      int unsigned   pos;
      bit            is_zero;
      bit            is_one;
      ir_report_type r;
      if (count_seen == 0) begin
         frame_good  = pair_hits(m, s, cfg_now.leader_mark, cfg_now.leader_space);
         repeat_good = pair_hits(m, s, nec_ir_pkg::REPEAT_MARK_TICKS_DEF,
                                 cfg_now.repeat_space);
      end else if (count_seen <= nec_ir_pkg::DATA_LAST) begin
         pos     = (count_seen - 1) % nec_ir_pkg::HALF_W;
         is_zero = pair_hits(m, s, cfg_now.zero_mark, cfg_now.zero_space);
         is_one  = pair_hits(m, s, cfg_now.one_mark, cfg_now.one_space);
         if (!is_zero && !is_one)
            frame_good = 1'b0;
         if (count_seen <= nec_ir_pkg::ADDR_LAST)
            addr_bits[pos] = !is_zero && is_one;
         else
            cmd_bits[pos] = !is_zero && is_one;
      end
      if (count_seen < nec_ir_pkg::MAX_SYMBOLS_DEF)
         count_seen++;
      if (last) begin
         if (count_seen == nec_ir_pkg::FRAME_LEN) begin
            if (frame_good) begin
               held_addr = addr_bits;
               held_cmd  = cmd_bits;
               r.status  = nec_ir_pkg::ST_NEW;
            end else begin
               r.status = nec_ir_pkg::ST_REJECT;
            end
         end else if (count_seen == nec_ir_pkg::REPEAT_LEN) begin
            r.status = repeat_good ? nec_ir_pkg::ST_REPEAT : nec_ir_pkg::ST_REJECT;
         end else begin
            r.status = nec_ir_pkg::ST_UNKNOWN;
         end
         r.address = held_addr;
         r.command = held_cmd;
         r.key     = held_cmd[nec_ir_pkg::KEY_W-1:0];
         reports_due.push_back(r);
         count_seen  = 0;
         frame_good  = 1'b1;
         repeat_good = 1'b0;
      end
   endtask

   // driver: also keeps the model's copy of the timing registers
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               nec_ir_pkg::REG_LEADER_MARK:  cfg_now.leader_mark  = csr_tick;
               nec_ir_pkg::REG_LEADER_SPACE: cfg_now.leader_space = csr_tick;
               nec_ir_pkg::REG_ZERO_MARK:    cfg_now.zero_mark    = csr_tick;
               nec_ir_pkg::REG_ZERO_SPACE:   cfg_now.zero_space   = csr_tick;
               nec_ir_pkg::REG_ONE_MARK:     cfg_now.one_mark     = csr_tick;
               nec_ir_pkg::REG_ONE_SPACE:    cfg_now.one_space    = csr_tick;
               nec_ir_pkg::REG_REPEAT_SPACE: cfg_now.repeat_space = csr_tick;
               nec_ir_pkg::REG_TOLERANCE:    cfg_now.tolerance    = csr_tick;
               default: ;
            endcase
         end
         sent_now = req_valid && !req_stall;
         if (sent_now) begin
            decode_symbol(req_mark_ticks, req_space_ticks, req_burst_end);
            symbols_sent++;
         end
         if (sent_now || !req_valid) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!calm_tail && pending.size() > 0 && $urandom_range(9) == 0) begin
               gap_left = $urandom_range(5);
               req_valid <= 1'b0;
            end else if (pending.size() > 0) begin
               next_sym = pending.pop_front();
               req_valid       <= 1'b1;
               req_mark_ticks  <= next_sym.mark_ticks;
               req_space_ticks <= next_sym.space_ticks;
               req_burst_end   <= next_sym.burst_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= 10)
         $display("ERROR: %s", msg);
   endtask

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               flag_error($sformatf("unexpected report status %0d addr %h cmd %h key %h",
                                    rsp_status, rsp_device_address, rsp_device_command,
                                    rsp_key_code));
            end else begin
               want_report = reports_due.pop_front();
               if (rsp_status !== want_report.status
                   || rsp_device_address !== want_report.address
                   || rsp_device_command !== want_report.command
                   || rsp_key_code !== want_report.key)
                  flag_error($sformatf({"report %0d: expected status %0d addr %h cmd %h",
                                        " key %h, got status %0d addr %h cmd %h key %h"},
                                       reports_seen, want_report.status,
                                       want_report.address, want_report.command,
                                       want_report.key, rsp_status, rsp_device_address,
                                       rsp_device_command, rsp_key_code));
               status_tally[want_report.status]++;
               reports_seen++;
            end
         end
         // hold off long enough for a second burst end to back up the input
         if (!held_off && reports_seen >= HOLD_AFTER) begin
            held_off  = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm_tail && $urandom_range(7) == 0) begin
            stall_left = $urandom_range(5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= WATCH_MAX) begin
            $display("watchdog: no progress for %0d cycles", WATCH_MAX);
            $display("tb_nec_ir_frame_decoder failed");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [nec_ir_pkg::CSR_IDX_W-1:0] idx,
                            input logic [nec_ir_pkg::CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic program_timing(input nec_ir_pkg::cfg_type c, input bit top_bit);
      write_reg(nec_ir_pkg::REG_LEADER_MARK,  {top_bit, c.leader_mark});
      write_reg(nec_ir_pkg::REG_LEADER_SPACE, {top_bit, c.leader_space});
      write_reg(nec_ir_pkg::REG_ZERO_MARK,    {top_bit, c.zero_mark});
      write_reg(nec_ir_pkg::REG_ZERO_SPACE,   {top_bit, c.zero_space});
      write_reg(nec_ir_pkg::REG_ONE_MARK,     {top_bit, c.one_mark});
      write_reg(nec_ir_pkg::REG_ONE_SPACE,    {top_bit, c.one_space});
      write_reg(nec_ir_pkg::REG_REPEAT_SPACE, {top_bit, c.repeat_space});
      write_reg(nec_ir_pkg::REG_TOLERANCE,    {top_bit, c.tolerance});
   endtask

   task automatic drain();
      while (symbols_sent != symbols_queued || reports_due.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic add_sym(input int unsigned m, input int unsigned s, input bit last);
      pending.push_back(nec_ir_pkg::sym_type'({nec_ir_pkg::TICK_W'(m),
                                               nec_ir_pkg::TICK_W'(s), last}));
      symbols_queued++;
   endtask

   function automatic int unsigned raw_ticks();
      case ($urandom_range(5))
         0: return 0;
         1: return TICK_MAX;
         default: return $urandom_range(TICK_MAX);
      endcase
   endfunction

   // a duration inside the window of nom, or for bad_pct percent one at a window bound or at random
   function automatic int unsigned dur_near(input int unsigned nom, input int unsigned bad_pct);
      int unsigned lo_b;
      int unsigned hi_b;
      int unsigned v;
      lo_b = (nom > cfg_now.tolerance) ? nom - cfg_now.tolerance : 0;
      hi_b = nom + cfg_now.tolerance;
      if ($urandom_range(99) < bad_pct) begin
         case ($urandom_range(2))
            0: v = lo_b;
            1: v = hi_b;
            default: v = $urandom_range(TICK_MAX);
         endcase
      end else if (hi_b - lo_b < 2) begin
         v = nom;
      end else begin
         case ($urandom_range(3))
            0: v = lo_b + 1;
            1: v = hi_b - 1;
            default: v = $urandom_range(hi_b - 1, lo_b + 1);
         endcase
      end
      return (v > TICK_MAX) ? TICK_MAX : v;
   endfunction

   task automatic add_bit(input bit b, input int unsigned bad);
      if (b)
         add_sym(dur_near(cfg_now.one_mark, bad), dur_near(cfg_now.one_space, bad), 1'b0);
      else
         add_sym(dur_near(cfg_now.zero_mark, bad), dur_near(cfg_now.zero_space, bad), 1'b0);
   endtask

   task automatic add_frame(input int unsigned bad);
      logic [nec_ir_pkg::HALF_W-1:0] addr;
      logic [nec_ir_pkg::HALF_W-1:0] cmd;
      addr = nec_ir_pkg::HALF_W'($urandom);
      cmd  = nec_ir_pkg::HALF_W'($urandom);
      if ($urandom_range(1)) begin
         addr[nec_ir_pkg::HALF_W-1:nec_ir_pkg::KEY_W] = ~addr[nec_ir_pkg::KEY_W-1:0];
         cmd[nec_ir_pkg::HALF_W-1:nec_ir_pkg::KEY_W]  = ~cmd[nec_ir_pkg::KEY_W-1:0];
      end
      add_sym(dur_near(cfg_now.leader_mark, bad), dur_near(cfg_now.leader_space, bad), 1'b0);
      for (int i = 0; i < nec_ir_pkg::HALF_W; i++)
         add_bit(addr[i], bad);
      for (int i = 0; i < nec_ir_pkg::HALF_W; i++)
         add_bit(cmd[i], bad);
      add_sym(dur_near(cfg_now.zero_mark, 50), raw_ticks(), 1'b1);
   endtask

   task automatic add_odd(input int unsigned len);
      for (int unsigned k = 0; k < len; k++) begin
         if (k == 0 && $urandom_range(1))
            add_sym(dur_near(cfg_now.leader_mark, 10), dur_near(cfg_now.leader_space, 10),
                    len == 1);
         else if ($urandom_range(1))
            add_sym(dur_near(cfg_now.zero_mark, 10), dur_near(cfg_now.one_space, 10),
                    k == len - 1);
         else
            add_sym(raw_ticks(), raw_ticks(), k == len - 1);
      end
   endtask

   task automatic fill_random(input int unsigned budget);
      int unsigned start;
      int unsigned pick;
      int unsigned bad;
      start = symbols_queued;
      while (symbols_queued - start < budget) begin
         pick = $urandom_range(99);
         bad  = ($urandom_range(9) < 6) ? 0 : (($urandom_range(3) == 0) ? 20 : 2);
         if (pick < 45) begin
            add_frame(bad);
         end else if (pick < 70) begin
            add_sym(dur_near(nec_ir_pkg::REPEAT_MARK_TICKS_DEF, bad),
                    dur_near(cfg_now.repeat_space, bad), 1'b0);
            add_sym(raw_ticks(), raw_ticks(), 1'b1);
         end else if (pick < 90) begin
            case ($urandom_range(3))
               0: add_odd(nec_ir_pkg::FRAME_LEN - 1);
               1: add_odd(nec_ir_pkg::FRAME_LEN + 1);
               default: add_odd($urandom_range(40, 1));
            endcase
         end else begin
            add_odd($urandom_range(100, nec_ir_pkg::MAX_SYMBOLS_DEF - 4));
         end
      end
   endtask

   initial begin
      nec_ir_pkg::cfg_type c;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // short bursts at the edges of the standard windows
      add_sym(0, 0, 1'b1);
      add_sym(TICK_MAX, TICK_MAX, 1'b1);
      add_sym(9000, 2250, 1'b0);
      add_sym(560, 0, 1'b1);
      add_sym(8801, 2051, 1'b0);
      add_sym(0, TICK_MAX, 1'b1);
      add_sym(8800, 2250, 1'b0);
      add_sym(560, 560, 1'b1);
      add_sym(9000, 2450, 1'b0);
      add_sym(TICK_MAX, 0, 1'b1);
      add_sym(9000, 4500, 1'b0);
      add_sym(560, 1690, 1'b1);
      add_sym(9199, 4699, 1'b0);
      add_sym(560, 560, 1'b0);
      add_sym(560, 1690, 1'b1);
      fill_random(100);

      for (int phase = 1; phase <= 7; phase++) begin
         drain();
         c = NEC_STD;
         case (phase)
            1: begin
               c = {15'd4500, 15'd2250, 15'd280, 15'd280, 15'd280, 15'd845, 15'd1125,
                    15'd100};
            end
            2: begin
               // zero and one windows overlap: such symbols decode as zero
               c.zero_space = nec_ir_pkg::TICK_W'(800);
               c.one_space  = nec_ir_pkg::TICK_W'(900);
            end
            3: begin
               c = {15'd32767, 15'd0, 15'd0, 15'd32767, 15'd32767, 15'd0, 15'd0,
                    15'd32767};
            end
            4: c.tolerance = '0;
            5: begin
               c.tolerance    = nec_ir_pkg::TICK_W'(1);
               c.repeat_space = c.leader_space;
            end
            6: begin
               c.leader_mark  = nec_ir_pkg::TICK_W'($urandom_range(20000, 50));
               c.leader_space = nec_ir_pkg::TICK_W'($urandom_range(20000, 50));
               c.zero_mark    = nec_ir_pkg::TICK_W'($urandom_range(20000, 50));
               c.zero_space   = nec_ir_pkg::TICK_W'($urandom_range(20000, 50));
               c.one_mark     = nec_ir_pkg::TICK_W'($urandom_range(20000, 50));
               c.one_space    = nec_ir_pkg::TICK_W'($urandom_range(20000, 50));
               c.repeat_space = nec_ir_pkg::TICK_W'($urandom_range(20000, 50));
               c.tolerance    = nec_ir_pkg::TICK_W'($urandom_range(600, 1));
            end
            default: calm_tail = 1'b1;
         endcase
         program_timing(c, phase == 7);
         if (phase == 1)
            for (int j = nec_ir_pkg::REG_TOLERANCE + 1; j < (1 << nec_ir_pkg::CSR_IDX_W); j++)
               write_reg(nec_ir_pkg::CSR_IDX_W'(j), nec_ir_pkg::CSR_DAT_W'($urandom));
         setups_run++;
         @(negedge clock);
         case (phase)
            3, 4, 5: fill_random(50);
            6:       fill_random(100);
            7:       fill_random(80);
            default: fill_random(110);
         endcase
      end
      drain();

      $display("covered %0d symbols over %0d timing setups, %0d reports checked",
               symbols_sent, setups_run, reports_seen);
      $display("reports by status: new %0d, repeat %0d, rejected %0d, unknown %0d",
               status_tally[nec_ir_pkg::ST_NEW], status_tally[nec_ir_pkg::ST_REPEAT],
               status_tally[nec_ir_pkg::ST_REJECT], status_tally[nec_ir_pkg::ST_UNKNOWN]);
      if (errors == 0 && reports_due.size() == 0) begin
         $display("tb_nec_ir_frame_decoder passed");
      end else begin
         $display("%0d errors, %0d reports still due", errors, reports_due.size());
         $display("tb_nec_ir_frame_decoder failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/nec_ir_pkg.sv
hw/rtl/nec_ir_csr.sv
hw/rtl/nec_ir_in_stage.sv
hw/rtl/nec_ir_classify.sv
hw/rtl/nec_ir_frame.sv
hw/rtl/nec_ir_frame_decoder.sv
hw/rtl/nec_ir_checker.sv
tb/tb_nec_ir_frame_decoder.sv
